FILE: hw/rtl/tfd_pkg.sv
// Shared types, constants and register codes of the turbine flow detector.
package tfd_pkg;

  localparam int WINDOW_TICKS = 100;
  localparam int COUNTER_BITS = 16;
  localparam int CNT_W        = COUNTER_BITS;
  localparam int TICK_W       = $clog2(WINDOW_TICKS + 1);
  localparam int CMP_W        = (CNT_W > 16) ? CNT_W : 16;

  localparam int FAST_STEP = 10;
  localparam int FAST_LAST = 80;

  localparam int FLOW_W       = 14;
  localparam int FLOW_MAX     = 9999;
  localparam int FLOW_N_W     = 10;
  localparam int FLOW_SHIFT   = 28;
  localparam int FLOW_MUL_W   = 32;
  localparam int FLOW_PROD_W  = FLOW_N_W + FLOW_MUL_W + 1;
  localparam int FLOW_Q_W     = FLOW_PROD_W - FLOW_SHIFT;
  localparam logic [63:0] FLOW_SCALE  = 64'd1000000;
  localparam logic [63:0] FLOW_OFFSET = 64'd1455300;
  localparam logic [63:0] FLOW_DEN    = 64'd93808;
  localparam logic [FLOW_MUL_W-1:0] FLOW_MUL =
    FLOW_MUL_W'(((FLOW_SCALE << FLOW_SHIFT) + FLOW_DEN - 64'd1) / FLOW_DEN);
  localparam logic [FLOW_MUL_W-1:0] FLOW_ADD =
    FLOW_MUL_W'(((FLOW_OFFSET << FLOW_SHIFT) + FLOW_DEN - 64'd1) / FLOW_DEN);

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_MODULE_ENABLED = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SENSOR_TYPE    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ONE_LITER      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ON_THRESHOLD   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OFF_THRESHOLD  = 3'd4;

  localparam logic [1:0] SENSOR_CONTACT = 2'd0;
  localparam logic [1:0] SENSOR_TURBINE = 2'd1;
  localparam logic [1:0] SENSOR_OTHER   = 2'd2;
  localparam logic [1:0] SENSOR_SPARE   = 2'd3;

  typedef struct packed {
    logic        module_enabled;
    logic [1:0]  sensor_type;
    logic [15:0] one_liter_pulses;
    logic [15:0] on_threshold;
    logic [15:0] off_threshold;
  } cfg_t;

  typedef struct packed {
    logic [3:0] tick_pulses;
    logic       contact_level;
  } in_item_t;

  typedef struct packed {
    logic              demand_active;
    logic              drop_seen;
    logic              rise_seen;
    logic [15:0]       window_count;
    logic [FLOW_W-1:0] flow_centi;
  } out_item_t;

endpackage

FILE: hw/rtl/turbine_flow_detector.sv
// Top level of the turbine flow detector: input stage, update core and result stage.
//
// Each input item is one 10 ms tick carrying the turbine pulses seen in that tick
// and the level of the contact flow switch. Every accepted item yields exactly one
// result item with the demand, drop and rise flags, the count latched at the last
// window close and the flow in hundredths of a litre per minute.
// Both channels use valid and stall; an item moves when valid is high and stall
// is low. An item is held in the input register, the state update and flow
// conversion run combinationally, and the result lands in the output register.
// out_valid rises once the held item is stepped into the output register, and the
// block takes one item per cycle while the receiver does not stall; the flow
// conversion multiplier sets the cycle length. When the receiver stalls, the result
// waits in the output register and the input register still takes one more item;
// after that in_stall rises until the result is taken. Reset clears all measurement
// state and loads the register defaults. The user must write registers through the
// APB-style port only while no item is in flight; the block does not enforce this.
module turbine_flow_detector
  import tfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t      cfg;
  in_item_t  in_data_r;
  logic      in_valid_r;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t result;
  logic      advance;
  logic      step;
  logic      in_take;

  tfd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = !out_valid_r || !out_stall;
  assign step     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  tfd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_data_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_flow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.flow_centi <= FLOW_W'(FLOW_MAX))
    else $error("flow exceeds saturation limit");

  a_flow_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.flow_centi != '0 && out_data.window_count == '0))
    else $error("nonzero flow with empty window count");

  a_step_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && advance) |=> out_valid)
    else $error("held item did not reach the result register");

endmodule

FILE: hw/rtl/tfd_regs.sv
// Configuration register file with its APB-style access port.
module tfd_regs
  import tfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[REG_IDX_W+1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.module_enabled   <= 1'b0;
      cfg_r.sensor_type      <= SENSOR_TURBINE;
      cfg_r.one_liter_pulses <= 16'd10;
      cfg_r.on_threshold     <= 16'd27;
      cfg_r.off_threshold    <= 16'd22;
    end else if (wr_en) begin
      case (idx)
        REG_MODULE_ENABLED: cfg_r.module_enabled   <= pwdata[0];
        REG_SENSOR_TYPE:    cfg_r.sensor_type      <= pwdata[1:0];
        REG_ONE_LITER:      cfg_r.one_liter_pulses <= pwdata[15:0];
        REG_ON_THRESHOLD:   cfg_r.on_threshold     <= pwdata[15:0];
        REG_OFF_THRESHOLD:  cfg_r.off_threshold    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODULE_ENABLED: prdata = APB_DATA_W'(cfg_r.module_enabled);
      REG_SENSOR_TYPE:    prdata = APB_DATA_W'(cfg_r.sensor_type);
      REG_ONE_LITER:      prdata = APB_DATA_W'(cfg_r.one_liter_pulses);
      REG_ON_THRESHOLD:   prdata = APB_DATA_W'(cfg_r.on_threshold);
      REG_OFF_THRESHOLD:  prdata = APB_DATA_W'(cfg_r.off_threshold);
      default:            prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/tfd_flow.sv
// Window count to flow conversion in hundredths of a litre per minute.
module tfd_flow
  import tfd_pkg::*;
(
  input  logic [CNT_W-1:0]  count,
  output logic [FLOW_W-1:0] flow
);

  logic [CMP_W-1:0]       count_ext;
  logic                   over;
  logic [FLOW_N_W-1:0]    n;
  logic [FLOW_PROD_W-1:0] acc;
  logic [FLOW_Q_W-1:0]    q;

  assign count_ext = CMP_W'(count);
  assign over      = count_ext > CMP_W'((1 << FLOW_N_W) - 1);
  assign n         = FLOW_N_W'(count_ext);
  assign acc       = FLOW_PROD_W'(n) * FLOW_PROD_W'(FLOW_MUL) + FLOW_PROD_W'(FLOW_ADD);
  assign q         = acc[FLOW_PROD_W-1:FLOW_SHIFT];

  always_comb begin
    if (over || q > FLOW_Q_W'(FLOW_MAX)) begin
      flow = FLOW_W'(FLOW_MAX);
    end else begin
      flow = FLOW_W'(q);
    end
  end

endmodule

FILE: hw/rtl/tfd_core.sv
// Measurement state and per-tick update of the window, flags and flow.
module tfd_core
  import tfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic [CNT_W-1:0]  pulse_counter_r, pulse_counter_nxt;
  logic [TICK_W-1:0] tick_count_r, tick_count_nxt;
  logic [CNT_W-1:0]  previous_window_r, previous_window_nxt;
  logic [CNT_W-1:0]  latched_count_r, latched_count_nxt;
  logic [CNT_W-1:0]  fast_snapshot_r, fast_snapshot_nxt;
  logic              demand_r, demand_nxt;
  logic              drop_r, drop_nxt;
  logic              rise_r, rise_nxt;

  logic              pulse_mode;
  logic [CNT_W-1:0]  pc_sum;
  logic [TICK_W-1:0] tick_inc;
  logic              do_close;
  logic [FLOW_W-1:0] flow_raw;

  function automatic logic is_fast_tick(input logic [TICK_W-1:0] t);
    logic hit;
    hit = 1'b0;
    for (int k = 1; k <= FAST_LAST / FAST_STEP; k++) begin
      hit = hit | (t == TICK_W'(k * FAST_STEP));
    end
    return hit;
  endfunction

  assign pulse_mode = cfg.module_enabled && (cfg.sensor_type != SENSOR_CONTACT);
  assign pc_sum     = pulse_counter_r + CNT_W'(item.tick_pulses);
  assign tick_inc   = tick_count_r + TICK_W'(1);

  always_comb begin
    pulse_counter_nxt   = pc_sum;
    tick_count_nxt      = tick_count_r;
    previous_window_nxt = previous_window_r;
    latched_count_nxt   = latched_count_r;
    fast_snapshot_nxt   = fast_snapshot_r;
    demand_nxt          = demand_r;
    drop_nxt            = drop_r;
    rise_nxt            = rise_r;
    do_close            = 1'b0;
    if (pulse_mode) begin
      tick_count_nxt = tick_inc;
      if (tick_inc >= TICK_W'(WINDOW_TICKS)) begin
        do_close = 1'b1;
      end else if (is_fast_tick(tick_inc)) begin
        if (pc_sum == fast_snapshot_r && demand_r) begin
          demand_nxt = 1'b0;
          do_close   = 1'b1;
        end else begin
          fast_snapshot_nxt = pc_sum;
        end
      end
      if (do_close) begin
        if (previous_window_r > pc_sum) begin
          drop_nxt = CMP_W'(previous_window_r - pc_sum) >
                     CMP_W'(cfg.one_liter_pulses >> 1);
        end else begin
          rise_nxt = CMP_W'(pc_sum - previous_window_r) > CMP_W'(cfg.one_liter_pulses);
        end
        if (CMP_W'(pc_sum) >= CMP_W'(cfg.on_threshold)) begin
          demand_nxt = 1'b1;
        end
        if (CMP_W'(pc_sum) <= CMP_W'(cfg.off_threshold)) begin
          demand_nxt = 1'b0;
        end
        previous_window_nxt = pc_sum;
        latched_count_nxt   = pc_sum;
        pulse_counter_nxt   = '0;
        tick_count_nxt      = '0;
      end
    end else begin
      tick_count_nxt    = '0;
      latched_count_nxt = '0;
      drop_nxt          = 1'b0;
      rise_nxt          = 1'b0;
      demand_nxt        = !item.contact_level;
    end
  end

  tfd_flow u_flow (
    .count (latched_count_nxt),
    .flow  (flow_raw)
  );

  always_comb begin
    result.demand_active = demand_nxt;
    result.drop_seen     = drop_nxt;
    result.rise_seen     = rise_nxt;
    result.window_count  = 16'(CMP_W'(latched_count_nxt));
    if (pulse_mode && cfg.sensor_type == SENSOR_TURBINE && latched_count_nxt != '0) begin
      result.flow_centi = flow_raw;
    end else begin
      result.flow_centi = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_counter_r   <= '0;
      tick_count_r      <= '0;
      previous_window_r <= '0;
      latched_count_r   <= '0;
      fast_snapshot_r   <= '0;
      demand_r          <= 1'b0;
      drop_r            <= 1'b0;
      rise_r            <= 1'b0;
    end else if (step) begin
      pulse_counter_r   <= pulse_counter_nxt;
      tick_count_r      <= tick_count_nxt;
      previous_window_r <= previous_window_nxt;
      latched_count_r   <= latched_count_nxt;
      fast_snapshot_r   <= fast_snapshot_nxt;
      demand_r          <= demand_nxt;
      drop_r            <= drop_nxt;
      rise_r            <= rise_nxt;
    end
  end

endmodule
